// ===== rtl/lz77d_pkg.sv =====
// ----------------------------------------------------------------------------
// lz77d_pkg
// Shared constants, types and helpers of the LZ77 token decompressor.
// ----------------------------------------------------------------------------
package lz77d_pkg;

    localparam int HISTORY_DEPTH    = 65536;
    localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
    localparam int MAX_LENGTH       = 255;
    localparam int BYTES_PER_RESULT = 4;
    localparam int RESULT_BYTES     = (BYTES_PER_RESULT < 1) ? 1 :
                                      ((BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT);
    localparam int CNT_W            = 21;

    localparam logic [CNT_W-1:0] COUNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HIST_DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
    localparam logic [7:0]       MAX_LEN_C      = 8'(MAX_LENGTH);
    localparam logic [2:0]       RES_BYTES_C    = 3'(RESULT_BYTES);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_DIST = 2'd1;
    localparam logic [1:0] STATUS_SIZE     = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [7:0]       literal_byte;
        logic [15:0]      distance;
        logic [7:0]       match_length;
        logic             block_start;
        logic             block_end;
        logic [CNT_W-1:0] blk_size;
    } token_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            last;
        logic [1:0]      status;
    } chunk_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
        sat_inc = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
    endfunction

endpackage

// ===== rtl/lz77_token_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_token_decompressor
// LZ77 token decoder with a circular byte history in a synchronous RAM.
// ----------------------------------------------------------------------------
// Slave stream: one token per word. tuser is the token kind (0 literal,
// 1 match), tlast marks the last token of a block, tdata carries the rest.
// Master stream: results of up to four decoded bytes; tlast is set on the
// final result of each token, tdata carries bytes, byte count and status.
// A literal's byte passes through the collector register to the output
// register. A match reads the history RAM one byte per cycle while the
// collector can take it, pipelined behind the registered read data, and
// pauses after every four bytes while the collector hands over its word;
// the single read port of the history RAM sets that pace. A bad distance
// or a zero-length match yields a single result word with no history read.
// The next token is accepted while the last result of the previous one
// still waits in the output register.
// Reset clears the produced count, write position and all handshake state;
// the history RAM is not cleared. When the sink holds tready low the output
// register keeps its word, the collector fills and then the copy loop and
// the slave side stall until the sink takes the word.
// ----------------------------------------------------------------------------
module lz77_token_decompressor
    import lz77d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // literal_byte[7:0], distance[23:8], match_length[31:24],
    // block_start[32], blk_size[53:33], zero[55:54]
    input  logic [55:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte0[7:0], out_byte1[15:8], out_byte2[23:16], out_byte3[31:24],
    // byte_count[34:32], status[36:35], zero[39:37]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    token_t             tok;
    chunk_t             chunk;
    chunk_t             out_chunk;
    logic               chunk_valid;
    logic               chunk_ready;
    logic               ram_wr_en;
    logic [HIST_AW-1:0] ram_wr_addr;
    logic [7:0]         ram_wr_data;
    logic               ram_rd_en;
    logic [HIST_AW-1:0] ram_rd_addr;
    logic [7:0]         ram_rd_data;

    assign tok = '{req_type:     s_axis_tuser,
                   literal_byte: s_axis_tdata[7:0],
                   distance:     s_axis_tdata[23:8],
                   match_length: s_axis_tdata[31:24],
                   block_start:  s_axis_tdata[32],
                   block_end:    s_axis_tlast,
                   blk_size:     s_axis_tdata[53:33]};

    lz77d_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (s_axis_tvalid),
        .tok         (tok),
        .tok_ready   (s_axis_tready),
        .chunk_valid (chunk_valid),
        .chunk       (chunk),
        .chunk_ready (chunk_ready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    lz77d_history_ram #(
        .ADDR_W (HIST_AW),
        .DATA_W (8)
    ) u_history_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lz77d_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_valid (chunk_valid),
        .chunk       (chunk),
        .chunk_ready (chunk_ready),
        .out_valid   (m_axis_tvalid),
        .out_chunk   (out_chunk),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, out_chunk.status, out_chunk.count, out_chunk.data};
    assign m_axis_tlast = out_chunk.last;

endmodule

// ===== rtl/lz77d_history_ram.sv =====
// ----------------------------------------------------------------------------
// lz77d_history_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lz77d_history_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lz77d_ctrl.sv =====
// ----------------------------------------------------------------------------
// lz77d_ctrl
// Token decode, history copy loop and result collector.
// ----------------------------------------------------------------------------
module lz77d_ctrl
    import lz77d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  token_t             tok,
    output logic               tok_ready,
    output logic               chunk_valid,
    output chunk_t             chunk,
    input  logic               chunk_ready,
    output logic               ram_wr_en,
    output logic [HIST_AW-1:0] ram_wr_addr,
    output logic [7:0]         ram_wr_data,
    output logic               ram_rd_en,
    output logic [HIST_AW-1:0] ram_rd_addr,
    input  logic [7:0]         ram_rd_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COPY = 1'b1;

    logic               state_reg,     state_next;
    logic [HIST_AW-1:0] wr_pos_reg,    wr_pos_next;
    logic [CNT_W-1:0]   produced_reg,  produced_next;
    logic [7:0]         prev_byte_reg, prev_byte_next;
    logic [15:0]        dist_reg,      dist_next;
    logic               dist_one_reg,  dist_one_next;
    logic [7:0]         remain_reg,    remain_next;
    logic               bend_reg,      bend_next;
    logic [CNT_W-1:0]   bsize_reg,     bsize_next;
    logic               rd_valid_reg,  rd_valid_next;
    logic               rd_last_reg,   rd_last_next;

    logic [3:0][7:0]    col_data_reg,   col_data_next;
    logic [2:0]         col_fill_reg,   col_fill_next;
    logic               col_done_reg,   col_done_next;
    logic               col_last_reg,   col_last_next;
    logic [1:0]         col_status_reg, col_status_next;

    logic               accept;
    logic               move;
    logic [CNT_W-1:0]   base_cnt;
    logic [CNT_W-1:0]   base_inc;
    logic [CNT_W-1:0]   prod_inc;
    logic [7:0]         len_sat;
    logic               dist_bad;
    logic [7:0]         arr_byte;
    logic [2:0]         fill_inc;

    assign tok_ready   = (state_reg == ST_IDLE) && (!col_done_reg || chunk_ready);
    assign accept      = tok_valid && tok_ready;
    assign move        = col_done_reg && chunk_ready;
    assign chunk_valid = col_done_reg;
    assign chunk       = '{data: col_data_reg, count: col_fill_reg,
                           last: col_last_reg, status: col_status_reg};

    assign base_cnt = tok.block_start ? '0 : produced_reg;
    assign base_inc = sat_inc(base_cnt);
    assign prod_inc = sat_inc(produced_reg);
    assign len_sat  = (tok.match_length > MAX_LEN_C) ? MAX_LEN_C : tok.match_length;
    assign dist_bad = (tok.distance == 16'd0)
                   || ({{(CNT_W-16){1'b0}}, tok.distance} > base_cnt)
                   || ({{(CNT_W-16){1'b0}}, tok.distance} > HIST_DEPTH_CNT);
    assign arr_byte = dist_one_reg ? prev_byte_reg : ram_rd_data;
    assign fill_inc = col_fill_reg + 3'd1;

    always_comb
    begin
        state_next      = state_reg;
        wr_pos_next     = wr_pos_reg;
        produced_next   = produced_reg;
        prev_byte_next  = prev_byte_reg;
        dist_next       = dist_reg;
        dist_one_next   = dist_one_reg;
        remain_next     = remain_reg;
        bend_next       = bend_reg;
        bsize_next      = bsize_reg;
        rd_valid_next   = 1'b0;
        rd_last_next    = rd_last_reg;
        col_data_next   = col_data_reg;
        col_fill_next   = col_fill_reg;
        col_done_next   = col_done_reg;
        col_last_next   = col_last_reg;
        col_status_next = col_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wr_pos_reg;
        ram_wr_data     = arr_byte;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = wr_pos_reg + {{(HIST_AW-1){1'b0}}, rd_valid_reg}
                        - dist_reg[HIST_AW-1:0];

        // hand the finished word to the output register
        if (move)
        begin
            col_data_next   = '0;
            col_fill_next   = 3'd0;
            col_done_next   = 1'b0;
            col_last_next   = 1'b0;
            col_status_next = STATUS_OK;
        end

        if (accept)
        begin
            if (!tok.req_type)
            begin
                ram_wr_en        = 1'b1;
                ram_wr_data      = tok.literal_byte;
                wr_pos_next      = wr_pos_reg + 1'b1;
                produced_next    = base_inc;
                prev_byte_next   = tok.literal_byte;
                col_data_next[0] = tok.literal_byte;
                col_fill_next    = 3'd1;
                col_done_next    = 1'b1;
                col_last_next    = 1'b1;
                col_status_next  = (tok.block_end && (base_inc != tok.blk_size))
                                 ? STATUS_SIZE : STATUS_OK;
            end
            else
            begin
                produced_next = base_cnt;
                if (dist_bad)
                begin
                    col_done_next   = 1'b1;
                    col_last_next   = 1'b1;
                    col_status_next = STATUS_BAD_DIST;
                end
                else if (len_sat == 8'd0)
                begin
                    col_done_next   = 1'b1;
                    col_last_next   = 1'b1;
                    col_status_next = (tok.block_end && (base_cnt != tok.blk_size))
                                    ? STATUS_SIZE : STATUS_OK;
                end
                else
                begin
                    state_next    = ST_COPY;
                    dist_next     = tok.distance;
                    dist_one_next = (tok.distance == 16'd1);
                    remain_next   = len_sat;
                    bend_next     = tok.block_end;
                    bsize_next    = tok.blk_size;
                end
            end
        end

        // read data arrives: append to history and to the collector
        if (rd_valid_reg)
        begin
            ram_wr_en      = 1'b1;
            ram_wr_data    = arr_byte;
            wr_pos_next    = wr_pos_reg + 1'b1;
            produced_next  = prod_inc;
            prev_byte_next = arr_byte;
            col_data_next[col_fill_reg[1:0]] = arr_byte;
            col_fill_next  = fill_inc;
            if ((fill_inc == RES_BYTES_C) || rd_last_reg)
            begin
                col_done_next   = 1'b1;
                col_last_next   = rd_last_reg;
                col_status_next = (rd_last_reg && bend_reg && (prod_inc != bsize_reg))
                                ? STATUS_SIZE : STATUS_OK;
            end
            if (rd_last_reg)
            begin
                state_next = ST_IDLE;
            end
        end

        // issue the next source read only when the collector can take it
        if ((state_reg == ST_COPY) && (remain_reg != 8'd0) && !col_done_next)
        begin
            ram_rd_en     = 1'b1;
            remain_next   = remain_reg - 8'd1;
            rd_valid_next = 1'b1;
            rd_last_next  = (remain_reg == 8'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_pos_reg     <= '0;
            produced_reg   <= '0;
            prev_byte_reg  <= '0;
            remain_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            col_data_reg   <= '0;
            col_fill_reg   <= '0;
            col_done_reg   <= 1'b0;
            col_last_reg   <= 1'b0;
            col_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            wr_pos_reg     <= wr_pos_next;
            produced_reg   <= produced_next;
            prev_byte_reg  <= prev_byte_next;
            remain_reg     <= remain_next;
            rd_valid_reg   <= rd_valid_next;
            rd_last_reg    <= rd_last_next;
            col_data_reg   <= col_data_next;
            col_fill_reg   <= col_fill_next;
            col_done_reg   <= col_done_next;
            col_last_reg   <= col_last_next;
            col_status_reg <= col_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        dist_one_reg <= dist_one_next;
        bend_reg     <= bend_next;
        bsize_reg    <= bsize_next;
    end

endmodule

// ===== rtl/lz77d_out_reg.sv =====
// ----------------------------------------------------------------------------
// lz77d_out_reg
// Output register of the result stream; parts the collector from the sink.
// ----------------------------------------------------------------------------
module lz77d_out_reg
    import lz77d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        chunk_valid,
    input  chunk_t      chunk,
    output logic        chunk_ready,
    output logic        out_valid,
    output chunk_t      out_chunk,
    input  logic        out_ready
);

    logic   valid_reg, valid_next;
    chunk_t data_reg;

    assign chunk_ready = !valid_reg || out_ready;
    assign valid_next  = chunk_valid || (valid_reg && !out_ready);
    assign out_valid   = valid_reg;
    assign out_chunk   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load a new word whenever one is offered and the register is free or being emptied
    always_ff @(posedge clk)
    begin
        if (chunk_valid && chunk_ready)
        begin
            data_reg <= chunk;
        end
    end

endmodule

// ===== tb/lz77_token_decompressor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz77_token_decompressor_tb
// Self-checking testbench of the LZ77 token decompressor. A driver feeds
// tokens from a queue and a monitor decodes every accepted token into its
// expected output words, then compares each output word field by field.
// Directed tokens cover the corner cases; random blocks follow under three
// back-pressure profiles.
// ----------------------------------------------------------------------------
module lz77_token_decompressor_tb;
    import lz77d_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    token_t      drv_token;
    logic        tok_taken;
    token_t      pending_tokens[$];
    chunk_t      expected_words[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          fail_count;
    int          queued_count;
    int          plan_count;

    // decoder shadow state
    logic [7:0]       hist_mem [0:HISTORY_DEPTH-1];
    logic [CNT_W-1:0] made_count;
    logic [15:0]      put_pos;

    lz77_token_decompressor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign s_axis_tdata = {2'b00, drv_token.blk_size, drv_token.block_start,
                           drv_token.match_length, drv_token.distance,
                           drv_token.literal_byte};
    assign s_axis_tuser = drv_token.req_type;
    assign s_axis_tlast = drv_token.block_end;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    task automatic store_byte(input logic [7:0] v);
        hist_mem[put_pos] = v;
        put_pos = put_pos + 16'd1;
        if (made_count != COUNT_MAX)
            made_count = made_count + 1'b1;
    endtask

    // Turn one accepted token into the output words it must produce.
    task automatic decode_token(input token_t t);
        chunk_t     w;
        logic [8:0] len;
        logic [7:0] v;
        int         i;
        w = '0;
        if (t.block_start)
            made_count = '0;
        if (!t.req_type) begin
            store_byte(t.literal_byte);
            w.data[0] = t.literal_byte;
            w.count   = 3'd1;
        end
        else if (t.distance == 16'd0 || CNT_W'(t.distance) > made_count) begin
            w.status = STATUS_BAD_DIST;
        end
        else begin
            len = (t.match_length > MAX_LEN_C) ? 9'(MAX_LEN_C) : 9'(t.match_length);
            for (i = 0; i < len; i++) begin
                // the source trails the write pointer, so overlaps repeat bytes
                v = hist_mem[16'(put_pos - t.distance)];
                store_byte(v);
                w.data[w.count[1:0]] = v;
                w.count = w.count + 3'd1;
                if (w.count == RES_BYTES_C && i + 1 < len) begin
                    expected_words = {expected_words, w};
                    w = '0;
                end
            end
        end
        w.last = 1'b1;
        if (w.status != STATUS_BAD_DIST && t.block_end && made_count != t.blk_size)
            w.status = STATUS_SIZE;
        expected_words = {expected_words, w};
    endtask

    // Queue a token and track the produced count that it leaves behind.
    task automatic add_token(input logic is_match, input logic [7:0] lit,
                             input logic [15:0] dist_val, input logic [7:0] len,
                             input logic bstart, input logic bend,
                             input logic size_right, input logic [20:0] bsize);
        token_t t;
        if (bstart)
            plan_count = 0;
        if (!is_match)
            plan_count++;
        else if (dist_val != 0 && dist_val <= plan_count)
            plan_count += len;
        t.req_type     = is_match;
        t.literal_byte = lit;
        t.distance     = dist_val;
        t.match_length = len;
        t.block_start  = bstart;
        t.block_end    = bend;
        t.blk_size     = (bend && size_right) ? 21'(plan_count) : bsize;
        pending_tokens = {pending_tokens, t};
        queued_count++;
    endtask

    task automatic add_random_blocks(input int n);
        int         target;
        int         blen;
        int         k;
        int         roll;
        int         avail;
        int         dmax;
        logic       bstart;
        logic       bend;
        logic [15:0] dist_val;
        logic [7:0]  len;
        target = queued_count + n;
        while (queued_count < target) begin
            blen = $urandom_range(12, 1);
            for (k = 0; k < blen; k++) begin
                bstart = (k == 0) && ($urandom_range(9) != 0);
                bend   = (k == blen - 1);
                avail  = bstart ? 0 : plan_count;
                roll   = $urandom_range(99);
                if (roll < 12) begin
                    // broken match: zero distance or reaching past the block
                    if (roll < 4 || avail >= 65535)
                        dist_val = 16'd0;
                    else
                        dist_val = 16'($urandom_range(65535, avail + 1));
                    add_token(1'b1, 8'($urandom()), dist_val, 8'($urandom()), bstart, bend,
                              $urandom_range(99) < 80, 21'($urandom()));
                end
                else if (roll < 50 || avail == 0) begin
                    add_token(1'b0, 8'($urandom()), 16'($urandom()), 8'($urandom()),
                              bstart, bend, $urandom_range(99) < 80, 21'($urandom()));
                end
                else begin
                    dmax = (avail > 65535) ? 65535 : avail;
                    if ($urandom_range(1))
                        dist_val = 16'($urandom_range((dmax < 8) ? dmax : 8, 1));
                    else
                        dist_val = 16'($urandom_range(dmax, 1));
                    roll = $urandom_range(99);
                    if (roll < 85)
                        len = 8'($urandom_range(16));
                    else if (roll < 95)
                        len = 8'($urandom_range(64, 17));
                    else
                        len = 8'($urandom_range(255, 65));
                    add_token(1'b1, 8'($urandom()), dist_val, len, bstart, bend,
                              $urandom_range(99) < 80, 21'($urandom()));
                end
            end
        end
    endtask

    task automatic wait_drained;
        while (pending_tokens.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // driver: advance to the next token once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || tok_taken)
            begin
                if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_token     <= pending_tokens.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on every accepted token, check every output word
    always @(posedge clk)
    begin : monitor
        chunk_t got;
        chunk_t want;
        tok_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_token(drv_token);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data   = m_axis_tdata[31:0];
                got.count  = m_axis_tdata[34:32];
                got.status = m_axis_tdata[36:35];
                got.last   = m_axis_tlast;
                if (expected_words.size() == 0)
                begin
                    note_failure($sformatf("unexpected word data %h last %b",
                                           m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.data !== want.data || got.count !== want.count ||
                        got.last !== want.last || got.status !== want.status)
                        note_failure($sformatf(
                            "expected bytes %h count %0d last %b status %0d, got bytes %h count %0d last %b status %0d",
                            want.data, want.count, want.last, want.status,
                            got.data, got.count, got.last, got.status));
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        drv_token     = '0;
        tok_taken     = 1'b0;
        made_count    = '0;
        put_pos       = '0;
        fail_count    = 0;
        queued_count  = 0;
        plan_count    = 0;
        send_idle_pct = 12;
        recv_idle_pct = 71;

        // directed corner cases
        add_token(1'b0, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_token(1'b0, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b0, 21'h1FFFFF);
        add_token(1'b0, 8'hA5, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd1, 8'd9, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd3, 8'd4, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'hFF, 16'd2, 8'd5, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd1, 8'd0, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd0, 8'd5, 1'b0, 1'b0, 1'b0, '0);
        // bad distance wins over the size check
        add_token(1'b1, 8'h00, 16'hFFFF, 8'd255, 1'b0, 1'b1, 1'b0, 21'd7);
        add_token(1'b1, 8'h00, 16'd1, 8'd255, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd200, 8'd13, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b0, 8'h5A, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, '0);
        add_token(1'b0, 8'h3C, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b0, 21'h1FFFFF);
        add_token(1'b1, 8'h00, 16'd1, 8'd4, 1'b1, 1'b0, 1'b0, '0);
        add_token(1'b0, 8'h81, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd1, 8'd0, 1'b0, 1'b1, 1'b1, '0);
        add_token(1'b0, 8'h7E, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_token(1'b1, 8'h00, 16'd1, 8'd0, 1'b0, 1'b1, 1'b0, 21'h100000);
        add_token(1'b0, 8'h42, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, '0);
        add_random_blocks(120);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait_drained();
        send_idle_pct = 71;
        recv_idle_pct = 12;
        add_random_blocks(120);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_blocks(120);
        wait_drained();

        // catch stray words after the last expected one
        repeat (40) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("lz77_token_decompressor regression: pass");
        else
            $display("lz77_token_decompressor regression: fail");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("lz77_token_decompressor regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lz77d_pkg.sv
rtl/lz77d_history_ram.sv
rtl/lz77d_ctrl.sv
rtl/lz77d_out_reg.sv
rtl/lz77_token_decompressor.sv
tb/lz77_token_decompressor_tb.sv
